FILE: hw/rtl/agr_pkg.sv
// shared types and constants of the autoregressive grouped risk block
`default_nettype none
package agr_pkg;

  localparam int unsigned IN_W       = 16;
  localparam int unsigned THETA_W    = 15;
  localparam int unsigned TERM_W     = 40;
  localparam int unsigned GRP_W      = 48;
  localparam int unsigned ACC_W      = 52;
  localparam int unsigned RISK_W     = 48;
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned OBS_SHIFT  = 24;
  localparam int unsigned TH_SHIFT   = 14;
  localparam int unsigned COUNT_WIDTH_DEF = 32;

  typedef logic signed [IN_W-1:0]    in_t;
  typedef logic signed [THETA_W-1:0] theta_t;
  typedef logic signed [TERM_W-1:0]  term_v_t;
  typedef logic signed [GRP_W-1:0]   grp_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [49:0]        mul_a_t;
  typedef logic signed [24:0]        mul_b_t;
  typedef logic signed [74:0]        prod_t;
  typedef logic [127:0]              wide_t;
  typedef logic signed [63:0]        tot_t;
  typedef logic [63:0]               utot_t;
  typedef logic [RISK_W-1:0]         risk_t;

  localparam acc_t GRP_HI = (acc_t'(1) <<< 47) - acc_t'(1);
  localparam acc_t GRP_LO = -GRP_HI;

  // per-observation terms handed from the front to the back
  typedef struct packed {
    term_v_t t1;
    term_v_t t2;
    term_v_t lx;
    term_v_t lc;
    logic    gend;
    logic    dend;
  } term_t;

  function automatic grp_t clamp_grp(input acc_t v);
    grp_t r;
    if (v > GRP_HI) begin
      r = grp_t'(GRP_HI);
    end else if (v < GRP_LO) begin
      r = grp_t'(GRP_LO);
    end else begin
      r = v[GRP_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/agr_if.sv
// channel interfaces: observations in, risk out, theta write
`default_nettype none
interface agr_obs_if;
  logic           valid;
  logic           ready;
  agr_pkg::in_t   weight;
  agr_pkg::in_t   xi_residual;
  agr_pkg::in_t   eps_residual;
  logic           group_end;
  logic           data_end;
  modport source(output valid, weight, xi_residual, eps_residual, group_end, data_end,
                 input ready);
  modport sink(input valid, weight, xi_residual, eps_residual, group_end, data_end,
               output ready);
endinterface

interface agr_res_if;
  logic           valid;
  logic           ready;
  agr_pkg::risk_t risk;
  logic           zero_denominator;
  modport source(output valid, risk, zero_denominator, input ready);
  modport sink(input valid, risk, zero_denominator, output ready);
endinterface

interface agr_cfg_if;
  logic            valid;
  logic            ready;
  agr_pkg::theta_t theta;
  modport source(output valid, theta, input ready);
  modport sink(input valid, theta, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/agr_front.sv
// front end: per-observation products, one register stage
`default_nettype none
module agr_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire agr_pkg::in_t  weight_i,
  input  wire agr_pkg::in_t  xi_i,
  input  wire agr_pkg::in_t  eps_i,
  input  wire logic          gend_i,
  input  wire logic          dend_i,
  output logic               push_o,
  input  wire logic          push_ready_i,
  output agr_pkg::term_t     term_o
);

  logic               s1_valid_q;
  logic signed [31:0] p_sx_q, p_ss_q, p_xe_q, p_pp_q, p_ps_q, p_xpe_q, p_pxe_q;
  logic               gend_q, dend_q;
  agr_pkg::in_t       prev_w_q, prev_x_q, prev_e_q;
  logic               accept;
  logic signed [32:0] cross_sum;
  logic signed [63:0] t1_full, t2_full, lx_full, lc_full;

  assign in_ready_o = !s1_valid_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // prev values only matter from the second word of a group on
  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_sx_q   <= 32'(weight_i) * 32'(xi_i);
      p_ss_q   <= 32'(weight_i) * 32'(weight_i);
      p_xe_q   <= 32'(xi_i) * 32'(eps_i);
      p_pp_q   <= 32'(prev_w_q) * 32'(prev_x_q);
      p_ps_q   <= 32'(prev_w_q) * 32'(weight_i);
      p_xpe_q  <= 32'(xi_i) * 32'(prev_e_q);
      p_pxe_q  <= 32'(prev_x_q) * 32'(eps_i);
      gend_q   <= gend_i;
      dend_q   <= dend_i;
      prev_w_q <= weight_i;
      prev_x_q <= xi_i;
      prev_e_q <= eps_i;
    end
  end

  assign cross_sum = 33'(p_xpe_q) + 33'(p_pxe_q);
  assign t1_full   = 64'(p_sx_q) * 64'(p_sx_q);
  assign t2_full   = 64'(p_ss_q) * 64'(p_xe_q);
  assign lx_full   = 64'(p_pp_q) * 64'(p_sx_q);
  assign lc_full   = 64'(p_ps_q) * 64'(cross_sum);

  assign push_o      = s1_valid_q;
  assign term_o.t1   = agr_pkg::term_v_t'(t1_full >>> agr_pkg::OBS_SHIFT);
  assign term_o.t2   = agr_pkg::term_v_t'(t2_full >>> agr_pkg::OBS_SHIFT);
  assign term_o.lx   = agr_pkg::term_v_t'(lx_full >>> agr_pkg::OBS_SHIFT);
  assign term_o.lc   = agr_pkg::term_v_t'(lc_full >>> agr_pkg::OBS_SHIFT);
  assign term_o.gend = gend_q;
  assign term_o.dend = dend_q;

endmodule
`default_nettype wire

FILE: hw/rtl/agr_queue.sv
// short term queue between front and back
`default_nettype none
module agr_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  output logic                push_ready_o,
  input  wire agr_pkg::term_t push_data_i,
  input  wire logic           pop_i,
  output logic                head_valid_o,
  output agr_pkg::term_t      head_o
);

  localparam int unsigned PTR_W = $clog2(agr_pkg::QDEPTH);
  localparam int unsigned CNT_W = $clog2(agr_pkg::QDEPTH + 1);

  agr_pkg::term_t   mem_q [agr_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign push_ready_o = cnt_q != CNT_W'(agr_pkg::QDEPTH);
  assign head_valid_o = cnt_q != '0;
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/agr_back.sv
// back end: group sums, group close, totals and final division
`default_nettype none
module agr_back #(
  parameter int unsigned COUNT_WIDTH = agr_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_valid_i,
  input  wire agr_pkg::theta_t cfg_theta_i,
  input  wire logic            head_valid_i,
  input  wire agr_pkg::term_t  head_i,
  output logic                 pop_o,
  output logic                 res_valid_o,
  input  wire logic            res_ready_i,
  output agr_pkg::risk_t       risk_o,
  output logic                 zero_den_o
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_CLOSE  = 8'b0000_0010,
    ST_TOTAL  = 8'b0000_0100,
    ST_WMUL   = 8'b0000_1000,
    ST_WDONE  = 8'b0001_0000,
    ST_DIVCHK = 8'b0010_0000,
    ST_DIV    = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE, OP_A1_ADD, OP_A1_SUB, OP_A2_ADD, OP_A2_SUB, OP_WIDE
  } op_e;

  typedef enum logic [1:0] {PH_SQ, PH_DEN, PH_REM} phase_e;

  localparam logic [2:0] WLAST   = 3'd5;
  localparam logic [5:0] DIVLAST = 6'd47;

  state_e             state_q, state_d;
  agr_pkg::theta_t    theta_q;
  logic [14:0]        th2_q;
  logic signed [29:0] th_sq;

  agr_pkg::grp_t      sq_q, cross_q, lagx_q, lagc_q;
  agr_pkg::term_v_t   fsq_q, fcr_q, last1_q, last2_q;
  logic [1:0]         cnt_q;
  logic               dend_q, zflag_q;
  logic [COUNT_WIDTH-1:0] obs_q;
  agr_pkg::tot_t      tot_a1_q;
  agr_pkg::utot_t     tot_sq_q;

  logic [1:0]         k_q;
  logic [2:0]         j_q;
  logic [5:0]         div_q;
  agr_pkg::acc_t      a1_q, a2_q;
  agr_pkg::prod_t     prod_q;
  op_e                op_q;
  logic [2:0]         ptag_q;
  phase_e             phase_q;
  agr_pkg::utot_t     wx_q, wy_q;
  agr_pkg::wide_t     wacc_q, den_q, rem_q;
  agr_pkg::risk_t     quo_q;

  logic               res_valid_q, zero_q;
  agr_pkg::risk_t     risk_q;

  // operand selection of the shared multiplier
  agr_pkg::mul_a_t    mul_a;
  agr_pkg::mul_b_t    mul_b;
  op_e                mul_op;
  agr_pkg::prod_t     prod;
  logic [14:0]        one_minus;
  agr_pkg::mul_b_t    c_single;
  agr_pkg::mul_a_t    rest1, rest2;
  logic [1:0]         klast;

  // word accept and group update
  logic               pop;
  logic [1:0]         cnt_new;
  agr_pkg::grp_t      sq_new, cross_new;
  agr_pkg::acc_t      pshift;
  agr_pkg::grp_t      a1c, a2c;
  logic signed [64:0] tot_sum;
  agr_pkg::tot_t      tot_a1_new;
  logic [64:0]        sq_sum;
  agr_pkg::utot_t     a2_mag, a1_mag;
  agr_pkg::wide_t     rem2;
  logic               rem_ge;
  logic               out_free;

  function automatic logic [6:0] wide_shift(input logic [2:0] j);
    logic [6:0] s;
    unique case (j)
      3'd0:    s = 7'd0;
      3'd1:    s = 7'd24;
      3'd2:    s = 7'd48;
      3'd3:    s = 7'd49;
      3'd4:    s = 7'd73;
      3'd5:    s = 7'd97;
      default: s = 7'd0;
    endcase
    return s;
  endfunction

  assign th_sq     = 30'(theta_q) * 30'(theta_q);
  assign one_minus = 15'(15'd16384 - th2_q);
  assign c_single  = {9'd0, one_minus, 1'b0};
  assign rest1     = agr_pkg::mul_a_t'(sq_q) - agr_pkg::mul_a_t'(fsq_q)
                   - agr_pkg::mul_a_t'(last1_q);
  assign rest2     = agr_pkg::mul_a_t'(cross_q) - agr_pkg::mul_a_t'(fcr_q)
                   - agr_pkg::mul_a_t'(last2_q);
  assign klast     = (cnt_q == 2'd3) ? 2'd3 : 2'd1;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_op = OP_NONE;
    if (state_q == ST_CLOSE) begin
      if (cnt_q == 2'd1) begin
        mul_b  = c_single;
        mul_a  = (k_q == 2'd0) ? agr_pkg::mul_a_t'(last1_q) : agr_pkg::mul_a_t'(last2_q);
        mul_op = (k_q == 2'd0) ? OP_A1_ADD : OP_A2_ADD;
      end else begin
        unique case (k_q)
          2'd0: begin
            mul_a  = agr_pkg::mul_a_t'(lagx_q);
            mul_b  = {{9{theta_q[14]}}, theta_q, 1'b0};
            mul_op = OP_A1_SUB;
          end
          2'd1: begin
            mul_a  = agr_pkg::mul_a_t'(lagc_q);
            mul_b  = agr_pkg::mul_b_t'(theta_q);
            mul_op = OP_A2_SUB;
          end
          2'd2: begin
            mul_a  = rest1;
            mul_b  = {10'd0, th2_q};
            mul_op = OP_A1_ADD;
          end
          default: begin
            mul_a  = rest2;
            mul_b  = {10'd0, th2_q};
            mul_op = OP_A2_ADD;
          end
        endcase
      end
    end else if (state_q == ST_WMUL) begin
      // 49-bit limbs of x against 24-bit limbs of y
      mul_a  = (j_q < 3'd3) ? {1'b0, wx_q[48:0]} : {35'd0, wx_q[63:49]};
      mul_op = OP_WIDE;
      unique case (j_q)
        3'd0, 3'd3: mul_b = {1'b0, wy_q[23:0]};
        3'd1, 3'd4: mul_b = {1'b0, wy_q[47:24]};
        default:    mul_b = {9'd0, wy_q[63:48]};
      endcase
    end
  end

  assign prod = agr_pkg::prod_t'(mul_a) * agr_pkg::prod_t'(mul_b);

  assign pop       = (state_q == ST_IDLE) && head_valid_i;
  assign pop_o     = pop;
  assign cnt_new   = (cnt_q == 2'd3) ? 2'd3 : cnt_q + 2'd1;
  assign sq_new    = agr_pkg::clamp_grp(agr_pkg::acc_t'(sq_q) + agr_pkg::acc_t'(head_i.t1));
  assign cross_new = agr_pkg::clamp_grp(agr_pkg::acc_t'(cross_q) + agr_pkg::acc_t'(head_i.t2));

  assign pshift     = agr_pkg::acc_t'(prod_q >>> agr_pkg::TH_SHIFT);
  assign a1c        = agr_pkg::clamp_grp(a1_q);
  assign a2c        = agr_pkg::clamp_grp(a2_q);
  assign tot_sum    = 65'(tot_a1_q) + 65'(a1c);
  assign tot_a1_new = (tot_sum[64] != tot_sum[63])
                    ? {tot_sum[64], {63{~tot_sum[64]}}} : tot_sum[63:0];
  assign sq_sum     = {1'b0, tot_sq_q} + {1'b0, wacc_q[95:32]};
  assign a2_mag     = a2c[47] ? 64'(-agr_pkg::tot_t'(a2c)) : 64'(a2c);
  assign a1_mag     = tot_a1_q[63] ? agr_pkg::utot_t'(-tot_a1_q) : agr_pkg::utot_t'(tot_a1_q);
  assign rem2       = {rem_q[126:0], 1'b0};
  assign rem_ge     = rem2 >= den_q;
  assign out_free   = !res_valid_q || res_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop && (head_i.gend || head_i.dend)) begin
          state_d = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        if (k_q == klast) begin
          state_d = ST_TOTAL;
        end
      end
      ST_TOTAL: begin
        if (op_q == OP_NONE) begin
          state_d = ST_WMUL;
        end
      end
      ST_WMUL: begin
        if (j_q == WLAST) begin
          state_d = ST_WDONE;
        end
      end
      ST_WDONE: begin
        if (op_q == OP_NONE) begin
          priority case (phase_q)
            PH_SQ:   state_d = !dend_q ? ST_IDLE : (tot_a1_q == '0 ? ST_OUT : ST_WMUL);
            PH_DEN:  state_d = ST_WMUL;
            default: state_d = ST_DIVCHK;
          endcase
        end
      end
      ST_DIVCHK: state_d = (rem_q >= den_q) ? ST_OUT : ST_DIV;
      ST_DIV: begin
        if (div_q == DIVLAST) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      theta_q     <= '0;
      th2_q       <= '0;
      sq_q        <= '0;
      cross_q     <= '0;
      lagx_q      <= '0;
      lagc_q      <= '0;
      fsq_q       <= '0;
      fcr_q       <= '0;
      cnt_q       <= '0;
      obs_q       <= '0;
      tot_a1_q    <= '0;
      tot_sq_q    <= '0;
      op_q        <= OP_NONE;
      k_q         <= '0;
      j_q         <= '0;
      div_q       <= '0;
      zflag_q     <= 1'b0;
      dend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      th2_q   <= th_sq[28:14];
      op_q    <= mul_op;
      if (cfg_valid_i) begin
        theta_q <= cfg_theta_i;
      end
      // in ST_OUT the output register is reloaded below
      if (res_valid_q && res_ready_i && state_q != ST_OUT) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop) begin
            if (cnt_q == 2'd0) begin
              fsq_q <= head_i.t1;
              fcr_q <= head_i.t2;
            end else begin
              lagx_q <= agr_pkg::clamp_grp(agr_pkg::acc_t'(lagx_q) + agr_pkg::acc_t'(head_i.lx));
              lagc_q <= agr_pkg::clamp_grp(agr_pkg::acc_t'(lagc_q) + agr_pkg::acc_t'(head_i.lc));
            end
            sq_q    <= sq_new;
            cross_q <= cross_new;
            cnt_q   <= cnt_new;
            if (obs_q != '1) begin
              obs_q <= obs_q + COUNT_WIDTH'(1);
            end
            dend_q  <= head_i.dend;
            zflag_q <= 1'b0;
            k_q     <= '0;
          end
        end
        ST_CLOSE: begin
          k_q <= k_q + 2'd1;
        end
        ST_TOTAL: begin
          if (op_q == OP_NONE) begin
            tot_a1_q <= tot_a1_new;
            // group is closed: clear it for the next one
            sq_q    <= '0;
            cross_q <= '0;
            lagx_q  <= '0;
            lagc_q  <= '0;
            fsq_q   <= '0;
            fcr_q   <= '0;
            cnt_q   <= '0;
            j_q     <= '0;
          end
        end
        ST_WMUL: begin
          j_q <= j_q + 3'd1;
        end
        ST_WDONE: begin
          j_q <= '0;
          if (op_q == OP_NONE && phase_q == PH_SQ) begin
            tot_sq_q <= sq_sum[64] ? '1 : sq_sum[63:0];
            zflag_q  <= tot_a1_q == '0;
          end
        end
        ST_DIVCHK: begin
          div_q <= '0;
        end
        ST_DIV: begin
          div_q <= div_q + 6'd1;
        end
        ST_OUT: begin
          if (out_free) begin
            res_valid_q <= 1'b1;
            obs_q       <= '0;
            tot_a1_q    <= '0;
            tot_sq_q    <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod;
    ptag_q <= j_q;
    if (pop) begin
      last1_q <= head_i.t1;
      last2_q <= head_i.t2;
      a1_q    <= (cnt_new == 2'd1) ? '0 : agr_pkg::acc_t'(sq_new);
      a2_q    <= (cnt_new == 2'd1) ? '0 : agr_pkg::acc_t'(cross_new);
    end else begin
      unique case (op_q)
        OP_A1_ADD: a1_q <= a1_q + pshift;
        OP_A1_SUB: a1_q <= a1_q - pshift;
        OP_A2_ADD: a2_q <= a2_q + pshift;
        OP_A2_SUB: a2_q <= a2_q - pshift;
        default: begin
        end
      endcase
    end

    if (op_q == OP_WIDE) begin
      wacc_q <= wacc_q + (agr_pkg::wide_t'(prod_q[72:0]) << wide_shift(ptag_q));
    end else if (state_q == ST_TOTAL || state_q == ST_WDONE) begin
      wacc_q <= '0;
    end

    if (state_q == ST_TOTAL) begin
      wx_q    <= a2_mag;
      wy_q    <= a2_mag;
      phase_q <= PH_SQ;
    end else if (state_q == ST_WDONE && op_q == OP_NONE) begin
      unique case (phase_q)
        PH_SQ: begin
          wx_q    <= a1_mag;
          wy_q    <= a1_mag;
          phase_q <= PH_DEN;
        end
        PH_DEN: begin
          den_q   <= wacc_q;
          wx_q    <= agr_pkg::utot_t'(obs_q);
          wy_q    <= tot_sq_q;
          phase_q <= PH_REM;
        end
        default: begin
          rem_q <= wacc_q;
        end
      endcase
    end

    if (state_q == ST_DIVCHK) begin
      quo_q <= (rem_q >= den_q) ? '1 : '0;
    end else if (state_q == ST_DIV) begin
      rem_q <= rem_ge ? rem2 - den_q : rem2;
      quo_q <= {quo_q[46:0], rem_ge};
    end

    if (state_q == ST_OUT && out_free) begin
      risk_q <= zflag_q ? '0 : quo_q;
      zero_q <= zflag_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign risk_o      = risk_q;
  assign zero_den_o  = zero_q;

endmodule
`default_nettype wire

FILE: hw/rtl/autoregressive_grouped_risk.sv
// Autoregressive grouped risk: top level. A front pipeline takes one word per cycle while the
// queue has room and forms the four per-observation products behind one register stage; a
// four-entry queue feeds the back end, which folds each word into the group sums. A group end
// adds two to four products on the shared 50x25 multiplier, then six partial products to
// square A2. A data end adds twelve partial products for sum(A1)^2 and n_obs*sum(A2^2) and a
// restoring divide to a 48-bit quotient before the risk word is offered. Theta is written
// through its own channel, which is always ready, and must only change while the block
// is idle.
`default_nettype none
module autoregressive_grouped_risk #(
  parameter int unsigned COUNT_WIDTH = agr_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  agr_obs_if.sink    obs_i,
  agr_res_if.source  res_o,
  agr_cfg_if.sink    cfg_i
);

  logic           push, push_ready, pop, head_valid;
  agr_pkg::term_t push_data, head;

  assign cfg_i.ready = 1'b1;

  agr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (obs_i.valid),
    .in_ready_o   (obs_i.ready),
    .weight_i     (obs_i.weight),
    .xi_i         (obs_i.xi_residual),
    .eps_i        (obs_i.eps_residual),
    .gend_i       (obs_i.group_end),
    .dend_i       (obs_i.data_end),
    .push_o       (push),
    .push_ready_i (push_ready),
    .term_o       (push_data)
  );

  agr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  agr_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_theta_i  (cfg_i.theta),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .res_valid_o  (res_o.valid),
    .res_ready_i  (res_o.ready),
    .risk_o       (res_o.risk),
    .zero_den_o   (res_o.zero_denominator)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/agr_checker.sv
// port-level checks of the risk block and their binding
`default_nettype none
module agr_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_i,
  input wire logic           in_dend_i,
  input wire logic           res_valid_i,
  input wire logic           res_ready_i,
  input wire agr_pkg::risk_t risk_i,
  input wire logic           zero_i
);

  logic [7:0] pending_q;
  logic       in_end, out_word;

  assign in_end   = in_valid_i && in_ready_i && in_dend_i;
  assign out_word = res_valid_i && res_ready_i;

  // data ends taken whose risk word has not gone out yet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_end && !out_word) begin
      pending_q <= pending_q + 8'd1;
    end else if (out_word && !in_end) begin
      pending_q <= pending_q - 8'd1;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(risk_i) && $stable(zero_i))
    else $error("risk word changed while stalled");

  a_zero_risk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && zero_i |-> risk_i == '0)
    else $error("zero denominator with nonzero risk");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_word |-> pending_q != '0 || in_end)
    else $error("risk word without a data end");

endmodule

bind autoregressive_grouped_risk agr_checker u_agr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (obs_i.valid),
  .in_ready_i  (obs_i.ready),
  .in_dend_i   (obs_i.data_end),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .risk_i      (res_o.risk),
  .zero_i      (res_o.zero_denominator)
);
`default_nettype wire

FILE: test/agr_risk_checker.sv
// checker for the autoregressive grouped risk block: predicts and compares risk words
`timescale 1ns / 100ps
module agr_risk_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  agr_obs_if.sink    obs_i,
  agr_res_if.sink    res_i,
  agr_cfg_if.sink    cfg_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         risk_words_o,
  output int         zero_den_o
);

  localparam longint GRP_LIM = 64'sd140737488355327;
  localparam longint unsigned CNT_MAX = 64'd4294967295;

  typedef struct {
    logic [47:0] risk;
    logic        zden;
  } risk_word_t;

  risk_word_t risk_expected_q[$];

  longint theta_v;
  longint sq_xi, lag_xi, sq_cross, lag_cross, first_sq_xi, first_cross;
  longint prev_w, prev_x, prev_e;
  longint unsigned grp_n, obs_n;
  longint a1_total;
  longint unsigned a2sq_total;
  int mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = risk_expected_q.size();

  function automatic longint clamp48(input longint v);
    if (v > GRP_LIM) return GRP_LIM;
    if (v < -GRP_LIM) return -GRP_LIM;
    return v;
  endfunction

  function automatic longint unsigned sq_q16(input longint a);
    logic [127:0] p;
    longint unsigned m;
    m = a < 0 ? -a : a;
    p = 128'(m) * 128'(m);
    return p[95:32];
  endfunction

  task automatic fold_group(input longint last1, input longint last2);
    longint th2, a1, a2;
    logic signed [127:0] w;
    longint unsigned q;
    th2 = (theta_v * theta_v) >>> 14;
    if (grp_n == 1) begin
      a1 = (2 * last1 * (16384 - th2)) >>> 14;
      a2 = (2 * last2 * (16384 - th2)) >>> 14;
    end else begin
      a1 = sq_xi - ((theta_v * 2 * lag_xi) >>> 14);
      a2 = sq_cross - ((theta_v * lag_cross) >>> 14);
      if (grp_n > 2) begin
        a1 += (th2 * (sq_xi - first_sq_xi - last1)) >>> 14;
        a2 += (th2 * (sq_cross - first_cross - last2)) >>> 14;
      end
    end
    a1 = clamp48(a1);
    a2 = clamp48(a2);
    w = 128'(signed'(a1_total)) + 128'(signed'(a1));
    if (w > 128'sh7fffffffffffffff) a1_total = 64'h7fffffffffffffff;
    else if (w < -128'sh8000000000000000) a1_total = 64'h8000000000000000;
    else a1_total = w[63:0];
    q = sq_q16(a2);
    a2sq_total = (a2sq_total > ~64'd0 - q) ? ~64'd0 : a2sq_total + q;
    sq_xi = 0; lag_xi = 0; sq_cross = 0; lag_cross = 0;
    first_sq_xi = 0; first_cross = 0; prev_w = 0; prev_x = 0; prev_e = 0;
    grp_n = 0;
  endtask

  task automatic predict_obs(input longint s, input longint x, input longint e,
                             input logic gend, input logic dend);
    longint sxp, t1, t2, lx, lc;
    logic [127:0] num, den, mag;
    risk_word_t r;
    sxp = s * x;
    t1 = (sxp * sxp) >>> 24;
    t2 = ((s * s) * (x * e)) >>> 24;
    if (grp_n == 0) begin
      first_sq_xi = t1;
      first_cross = t2;
    end else begin
      lx = ((prev_w * prev_x) * sxp) >>> 24;
      lc = ((prev_w * s) * (x * prev_e + prev_x * e)) >>> 24;
      lag_xi = clamp48(lag_xi + lx);
      lag_cross = clamp48(lag_cross + lc);
    end
    sq_xi = clamp48(sq_xi + t1);
    sq_cross = clamp48(sq_cross + t2);
    prev_w = s; prev_x = x; prev_e = e;
    if (grp_n < CNT_MAX) grp_n++;
    if (obs_n < CNT_MAX) obs_n++;
    if (gend || dend) fold_group(t1, t2);
    if (dend) begin
      if (a1_total == 0) begin
        r.risk = '0;
        r.zden = 1'b1;
      end else begin
        // magnitude taken unsigned so the most negative total stays 2^63
        mag = a1_total < 0 ? 128'(unsigned'(-a1_total)) : 128'(a1_total);
        den = mag * mag;
        num = 128'(obs_n) * 128'(a2sq_total);
        if (num >= den) r.risk = '1;
        else r.risk = 48'((192'(num) << 48) / 192'(den));
        r.zden = 1'b0;
      end
      risk_expected_q.push_back(r);
      obs_n = 0; a1_total = 0; a2sq_total = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    risk_word_t exp_w;
    if (!rst_ni) begin
      theta_v = 0; sq_xi = 0; lag_xi = 0; sq_cross = 0; lag_cross = 0;
      first_sq_xi = 0; first_cross = 0; prev_w = 0; prev_x = 0; prev_e = 0;
      grp_n = 0; obs_n = 0; a1_total = 0; a2sq_total = 0;
      mismatches = 0; risk_words_o = 0; zero_den_o = 0;
      risk_expected_q.delete();
    end else begin
      if (cfg_i.valid && cfg_i.ready) theta_v = longint'(cfg_i.theta);
      if (obs_i.valid && obs_i.ready)
        predict_obs(longint'(obs_i.weight), longint'(obs_i.xi_residual),
                    longint'(obs_i.eps_residual), obs_i.group_end, obs_i.data_end);
      if (res_i.valid && res_i.ready) begin
        risk_words_o++;
        if (res_i.zero_denominator) zero_den_o++;
        if (risk_expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected risk word %h", res_i.risk);
        end else begin
          exp_w = risk_expected_q.pop_front();
          if (exp_w.risk !== res_i.risk || exp_w.zden !== res_i.zero_denominator) begin
            mismatches++;
            if (mismatches <= 10)
              $display("risk mismatch: expected %h zden %0d, got %h zden %0d",
                       exp_w.risk, exp_w.zden, res_i.risk, res_i.zero_denominator);
          end
        end
      end
    end
  end
endmodule

FILE: test/autoregressive_grouped_risk_tb.sv
// top of the autoregressive grouped risk testbench: stimulus and verdict
`timescale 1ns / 100ps
module autoregressive_grouped_risk_tb;

  localparam int CYCLE_LIMIT = 1500000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int fail_count, pending, risk_words, zero_dens;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int hold_cycles = 0;
  int cycle_count = 0;
  int obs_sent = 0;

  agr_obs_if obs_ch();
  agr_res_if res_ch();
  agr_cfg_if cfg_ch();

  autoregressive_grouped_risk dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .obs_i(obs_ch.sink), .res_o(res_ch.source),
    .cfg_i(cfg_ch.sink)
  );

  agr_risk_checker checker_u (
    .clk_i(clk_i), .rst_ni(rst_ni), .obs_i(obs_ch.sink), .res_i(res_ch.sink),
    .cfg_i(cfg_ch.sink), .fail_count_o(fail_count), .pending_o(pending),
    .risk_words_o(risk_words), .zero_den_o(zero_dens)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    obs_ch.valid = 1'b0; obs_ch.weight = '0; obs_ch.xi_residual = '0;
    obs_ch.eps_residual = '0; obs_ch.group_end = 1'b0; obs_ch.data_end = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.theta = '0;
    res_ch.ready = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off counted here
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      res_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("autoregressive_grouped_risk_tb failed");
      $finish;
    end
  end

  // valid stays up after a word so the next word can follow without a gap
  task automatic send_obs(input agr_pkg::in_t w, input agr_pkg::in_t x,
                          input agr_pkg::in_t e, input logic gend, input logic dend);
    while ($urandom_range(99) < send_idle_pct) begin
      obs_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    obs_ch.valid <= 1'b1;
    obs_ch.weight <= w;
    obs_ch.xi_residual <= x;
    obs_ch.eps_residual <= e;
    obs_ch.group_end <= gend;
    obs_ch.data_end <= dend;
    @(posedge clk_i);
    while (!obs_ch.ready) @(posedge clk_i);
    obs_sent++;
  endtask

  task automatic drain_results();
    obs_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // a data end with no group end in flight may still be busy; allow its latency
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_theta(input agr_pkg::theta_t th);
    cfg_ch.valid <= 1'b1;
    cfg_ch.theta <= th;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic agr_pkg::in_t rand_field();
    case ($urandom_range(5))
      0: return agr_pkg::in_t'(16'h8000);
      1: return agr_pkg::in_t'(16'h7fff);
      2: return agr_pkg::in_t'($urandom_range(8191) - 4096);
      default: return agr_pkg::in_t'($urandom());
    endcase
  endfunction

  // one data set of random groups; mostly short groups, sometimes long ones
  task automatic send_data_set(input int n_grp);
    int len;
    for (int g = 0; g < n_grp; g++) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 5);
      for (int k = 0; k < len; k++) begin
        // occasionally drop the group end on the last word
        send_obs(rand_field(), rand_field(), rand_field(),
                 (k == len - 1) && ($urandom_range(19) != 0),
                 (g == n_grp - 1) && (k == len - 1));
      end
    end
  endtask

  initial begin
    agr_pkg::theta_t th_set[5];
    th_set[0] = agr_pkg::theta_t'(15'h3fff); th_set[1] = agr_pkg::theta_t'(15'h4000);
    th_set[2] = '0; th_set[3] = agr_pkg::theta_t'(15'h2000);
    th_set[4] = agr_pkg::theta_t'(15'h7000);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, single and double groups, zero denominator, open group
    write_theta(agr_pkg::theta_t'(15'h3fff));
    send_obs(agr_pkg::in_t'(16'h7fff), agr_pkg::in_t'(16'h7fff), agr_pkg::in_t'(16'h7fff),
             1'b1, 1'b1);
    send_obs(agr_pkg::in_t'(16'h8000), agr_pkg::in_t'(16'h8000), agr_pkg::in_t'(16'h7fff),
             1'b1, 1'b1);
    send_obs('0, '0, '0, 1'b1, 1'b1);
    send_obs(agr_pkg::in_t'(16'h1000), agr_pkg::in_t'(16'h1000), agr_pkg::in_t'(16'h8000),
             1'b0, 1'b0);
    send_obs(agr_pkg::in_t'(16'h8000), agr_pkg::in_t'(16'h7fff), agr_pkg::in_t'(16'h1000),
             1'b1, 1'b0);
    send_obs(agr_pkg::in_t'(16'h7fff), agr_pkg::in_t'(16'h8000), agr_pkg::in_t'(16'h8000),
             1'b0, 1'b0);
    send_obs(agr_pkg::in_t'(16'h7fff), agr_pkg::in_t'(16'h7fff), agr_pkg::in_t'(16'h0001),
             1'b0, 1'b0);
    send_obs(agr_pkg::in_t'(16'hffff), agr_pkg::in_t'(16'h5555), agr_pkg::in_t'(16'haaaa),
             1'b0, 1'b1);
    drain_results();
    write_theta(agr_pkg::theta_t'(15'h4000));
    for (int k = 0; k < 6; k++)
      send_obs(agr_pkg::in_t'(16'h7fff), agr_pkg::in_t'(16'h7fff), agr_pkg::in_t'(16'h7fff),
               k == 2, k == 5);
    drain_results();
    write_theta('0);
    send_obs(agr_pkg::in_t'(16'h2000), agr_pkg::in_t'(16'h1000), agr_pkg::in_t'(16'h0fff),
             1'b1, 1'b0);
    send_obs(agr_pkg::in_t'(16'h2000), agr_pkg::in_t'(16'h1000), agr_pkg::in_t'(16'hf001),
             1'b0, 1'b1);
    drain_results();

    // random phases with theta settings and idle patterns
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 65 : 0;
      recv_idle_pct = (ph == 0) ? 65 : (ph == 1) ? 32 : 0;
      for (int r = 0; r < 2; r++) begin
        write_theta((ph == 2 && r == 1) ? agr_pkg::theta_t'($urandom())
                                        : th_set[(ph * 2 + r) % 5]);
        if (ph == 1 && r == 0) hold_cycles <= 600;
        for (int d = 0; d < 14; d++) send_data_set($urandom_range(1, 8));
        drain_results();
      end
    end

    $display("sent %0d observations, checked %0d risk words (%0d zero denominators)",
             obs_sent, risk_words, zero_dens);
    if (fail_count == 0 && pending == 0) begin
      $display("autoregressive_grouped_risk_tb passed");
    end else begin
      $display("autoregressive_grouped_risk_tb failed");
    end
    $finish;
  end
endmodule
